FILE: design/wlsm_pkg.sv
// Shared types and constants for the windowed latency statistics monitor.
// No dependencies; imported by wlsm_stats_ram and the core.
package wlsm_pkg;

  localparam int unsigned PROBE_W = 6;
  localparam int unsigned DUR_W   = 40;
  localparam int unsigned TS_W    = 47;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned IVL_W   = 32;

  localparam int unsigned S_TDATA_W = 96;   // 93 bits of fields, byte padded
  localparam int unsigned M_TDATA_W = 256;  // 253 bits of fields, byte padded
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned APB_DW    = 64;

  localparam logic [IVL_W-1:0] INTERVAL_RST = 32'd1000;
  localparam logic [DUR_W-1:0] LOW_THR_RST  = 40'd250000;
  localparam logic [DUR_W-1:0] HIGH_THR_RST = 40'd1000000;

  // register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_INTERVAL = 2'd0,
    REG_LOW_THR  = 2'd1,
    REG_HIGH_THR = 2'd2
  } reg_idx_e;

  // one row of per-probe statistics
  typedef struct packed {
    logic [CNT_W-1:0] high_cnt;
    logic [CNT_W-1:0] low_cnt;
    logic [DUR_W-1:0] peak;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } stats_entry_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

FILE: design/wlsm_stats_ram.sv
// Per-probe statistics store: synchronous RAM with registered read plus per-row valid bits.
// A row that is not valid reads as all zero. Depends on wlsm_pkg.
module wlsm_stats_ram #(
  parameter int unsigned NUM_PROBES = 64,
  parameter int unsigned IDX_W      = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [IDX_W-1:0]      rd_addr_i,
  output wlsm_pkg::stats_entry_t rd_data_o,
  input  logic                  wr_en_i,
  input  logic [IDX_W-1:0]      wr_addr_i,
  input  wlsm_pkg::stats_entry_t wr_data_i,
  input  logic                  clr_en_i,
  input  logic [IDX_W-1:0]      clr_addr_i
);
  import wlsm_pkg::*;

  stats_entry_t            mem [NUM_PROBES];
  stats_entry_t            rd_raw_q;
  logic                    rd_valid_q;
  logic [NUM_PROBES-1:0]   valid_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_raw_q <= mem[rd_addr_i];
    end
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (clr_en_i) begin
        valid_q[clr_addr_i] <= 1'b0;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_raw_q : '0;

endmodule

FILE: design/windowed_latency_stats_monitor_core.sv
// Windowed latency statistics monitor, top level.
// Depends on wlsm_pkg and wlsm_stats_ram.
//
// Usage:
//  - Slave stream takes one timing sample per item (probe, duration in ns,
//    timestamp in ms). Master stream gives one item per probe when a report
//    fires, probe 0 first, tlast on the last probe.
//  - APB port holds report_interval (0x00), low_threshold (0x08) and
//    high_threshold (0x10); write only while the block is idle.
//  - A sample is accepted with a RAM read, then its probe row gets a
//    read-modify-write; s_axis_tready is low in that update step, so no new
//    sample is taken before the last is written (single RAM port pair).
//  - A report walks the RAM row by row: a row read, then an output load,
//    stalling as needed. The first report item follows the trigger's update
//    step, a row read and the output load. No sample is taken during the walk.
//  - Stalls: the result sits in an output register; the walk waits while
//    that register is full and m_axis_tready is low. Nothing is dropped.
//  - Reset: registers take their defaults, the window closes, all rows read
//    as zero at once through per-row valid bits; no clearing pass is needed.
//    Rows are invalidated one by one as the report reads them.
module windowed_latency_stats_monitor_core #(
  parameter int unsigned NUM_PROBES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sample in: probe_id[5:0], duration[45:6], timestamp[92:46], zero pad
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [wlsm_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // report out: report_probe[5:0], window_length[52:6], sample_total[84:53],
  // duration_sum[148:85], duration_peak[188:149], above_low[220:189],
  // above_high[252:221], zero pad
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [wlsm_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,   // final_entry
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wlsm_pkg::APB_AW-1:0]    paddr,
  input  logic [wlsm_pkg::APB_DW-1:0]    pwdata,
  output logic [wlsm_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import wlsm_pkg::*;

  localparam int unsigned IDX_W = (NUM_PROBES > 1) ? $clog2(NUM_PROBES) : 1;
  localparam logic [PROBE_W-1:0] LAST_PROBE = PROBE_W'(NUM_PROBES - 1);
  localparam logic [PROBE_W:0]   PROBE_LIM  = (PROBE_W + 1)'(NUM_PROBES);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_UPD    = 4'b0010,
    ST_REP_RD = 4'b0100,
    ST_REP_WR = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // ---------------- configuration registers ----------------
  logic [IVL_W-1:0] interval_q;
  logic [DUR_W-1:0] low_thr_q, high_thr_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RST;
      low_thr_q  <= LOW_THR_RST;
      high_thr_q <= HIGH_THR_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_INTERVAL: interval_q <= pwdata[IVL_W-1:0];
        REG_LOW_THR:  low_thr_q  <= pwdata[DUR_W-1:0];
        REG_HIGH_THR: high_thr_q <= pwdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_INTERVAL: prdata = {{(APB_DW - IVL_W){1'b0}}, interval_q};
      REG_LOW_THR:  prdata = {{(APB_DW - DUR_W){1'b0}}, low_thr_q};
      REG_HIGH_THR: prdata = {{(APB_DW - DUR_W){1'b0}}, high_thr_q};
      default:      prdata = '0;
    endcase
  end

  // ---------------- sample capture ----------------
  logic               s_accept;
  logic [PROBE_W-1:0] in_probe;
  logic [DUR_W-1:0]   in_dur;
  logic [TS_W-1:0]    in_ts;
  logic [TS_W-1:0]    begin_eff;
  logic [TS_W:0]      diff;        // signed, one extra bit
  logic               report_hit;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_probe      = s_axis_tdata[5:0];
  assign in_dur        = s_axis_tdata[45:6];
  assign in_ts         = s_axis_tdata[92:46];

  logic               open_q;
  logic [TS_W-1:0]    begin_q;
  logic [TS_W-1:0]    ts_q;
  logic [TS_W-1:0]    elapsed_q;
  logic [PROBE_W-1:0] probe_q;
  logic [DUR_W-1:0]   dur_q;
  logic               in_range_q, ge_low_q, ge_high_q, report_q;

  // first sample opens the window at its own timestamp
  assign begin_eff  = open_q ? begin_q : in_ts;
  assign diff       = {1'b0, in_ts} - {1'b0, begin_eff};
  // negative elapsed time never reports
  assign report_hit = !diff[TS_W] &&
                      (diff[TS_W-1:0] >= {{(TS_W - IVL_W){1'b0}}, interval_q});

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      ts_q       <= in_ts;
      elapsed_q  <= diff[TS_W-1:0];
      probe_q    <= in_probe;
      dur_q      <= in_dur;
      in_range_q <= ({1'b0, in_probe} < PROBE_LIM);
      ge_low_q   <= (in_dur >= low_thr_q);
      ge_high_q  <= (in_dur >= high_thr_q);
    end
  end

  // ---------------- statistics RAM ----------------
  logic               rd_en, wr_en, clr_en;
  logic [IDX_W-1:0]   rd_addr;
  stats_entry_t       rd_data, wr_data;
  logic [PROBE_W-1:0] k_q;
  logic               out_free, out_load, rep_last;
  logic [SUM_W:0]     sum_ext;

  assign rd_en   = s_accept || (state_q == ST_REP_RD);
  assign rd_addr = s_accept ? in_probe[IDX_W-1:0] : k_q[IDX_W-1:0];

  wlsm_stats_ram #(
    .NUM_PROBES (NUM_PROBES),
    .IDX_W      (IDX_W)
  ) u_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .wr_en_i    (wr_en),
    .wr_addr_i  (probe_q[IDX_W-1:0]),
    .wr_data_i  (wr_data),
    .clr_en_i   (clr_en),
    .clr_addr_i (k_q[IDX_W-1:0])
  );

  // modify step: saturating count and sum, peak, threshold counters
  assign sum_ext = {1'b0, rd_data.sum} + (SUM_W + 1)'(dur_q);

  always_comb begin
    wr_data.count    = sat_inc(rd_data.count);
    wr_data.sum      = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    wr_data.peak     = (dur_q > rd_data.peak) ? dur_q : rd_data.peak;
    wr_data.low_cnt  = ge_low_q  ? sat_inc(rd_data.low_cnt)  : rd_data.low_cnt;
    wr_data.high_cnt = ge_high_q ? sat_inc(rd_data.high_cnt) : rd_data.high_cnt;
  end

  assign wr_en    = (state_q == ST_UPD) && in_range_q;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = (state_q == ST_REP_WR) && out_free;
  assign clr_en   = out_load;
  assign rep_last = (k_q == LAST_PROBE);

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (s_accept) state_d = ST_UPD;
      ST_UPD:    state_d = report_q ? ST_REP_RD : ST_IDLE;
      ST_REP_RD: state_d = ST_REP_WR;
      ST_REP_WR: if (out_load) state_d = rep_last ? ST_IDLE : ST_REP_RD;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      open_q   <= 1'b0;
      begin_q  <= '0;
      report_q <= 1'b0;
      k_q      <= '0;
    end else begin
      state_q <= state_d;
      if (s_accept) begin
        report_q <= report_hit;
        if (!open_q) begin
          open_q  <= 1'b1;
          begin_q <= in_ts;
        end
      end
      if (state_q == ST_UPD) begin
        k_q <= '0;
      end
      if (out_load) begin
        if (rep_last) begin
          begin_q <= ts_q;   // window restarts at the reporting sample
        end else begin
          k_q <= k_q + PROBE_W'(1);
        end
      end
    end
  end

  // ---------------- output register ----------------
  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;
  logic                 m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {3'b000, rd_data.high_cnt, rd_data.low_cnt, rd_data.peak,
                   rd_data.sum, rd_data.count, elapsed_q, k_q};
      m_last_q <= rep_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
  a_accept_to_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == ST_UPD))
    else $error("sample accept not followed by update step");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && rep_last) |=> (state_q == ST_IDLE) && m_axis_tvalid && m_axis_tlast)
    else $error("report did not end after the last probe");

  a_walk_needs_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REP_RD) |-> open_q)
    else $error("report walk with window closed");

  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_REP_RD) || (state_q == ST_REP_WR)) |-> !wr_en && !s_accept)
    else $error("statistics update during report walk");
`endif

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for windowed_latency_stats_monitor_core: random timing samples
// on the slave stream, per-probe reports checked on the master stream.
// Depends on wlsm_pkg and the core RTL.
module tb_top;
  import wlsm_pkg::*;

  localparam int unsigned PROBES      = 64;
  localparam int unsigned SETTLE_CYC  = 16;       // block latency margin before config/end
  localparam int unsigned HOLD_CYC    = 400;      // long receiver hold-off
  localparam longint      TIMEOUT_NS  = 64'd1_200_000 * 12;

  localparam logic [DUR_W-1:0] DUR_MAX = '1;
  localparam logic [TS_W-1:0]  TS_MAX  = '1;

  typedef struct {
    logic [PROBE_W-1:0] probe;
    logic [DUR_W-1:0]   dur;
    logic [TS_W-1:0]    ts;
  } timing_sample_t;

  // one item of a report: one probe's statistics for the closed window
  typedef struct {
    logic [PROBE_W-1:0] probe;
    logic [TS_W-1:0]    wlen;
    logic [CNT_W-1:0]   total;
    logic [SUM_W-1:0]   sum;
    logic [DUR_W-1:0]   peak;
    logic [CNT_W-1:0]   above_low;
    logic [CNT_W-1:0]   above_high;
    logic               last;
  } probe_stats_t;

  // Tracks the per-probe statistics and the window, queues the report items
  // each sample causes and checks the items that come out of the block.
  class probe_stats_tracker;
    logic [IVL_W-1:0]  interval;
    logic [DUR_W-1:0]  low_thr;
    logic [DUR_W-1:0]  high_thr;
    bit                win_open;
    logic [TS_W-1:0]   win_start;
    logic [CNT_W-1:0]  count_tab [PROBES];
    logic [SUM_W-1:0]  sum_tab [PROBES];
    logic [DUR_W-1:0]  peak_tab [PROBES];
    logic [CNT_W-1:0]  low_tab [PROBES];
    logic [CNT_W-1:0]  high_tab [PROBES];
    probe_stats_t      expected_reports[$];
    int                errors;

    function new();
      interval  = INTERVAL_RST;
      low_thr   = LOW_THR_RST;
      high_thr  = HIGH_THR_RST;
      win_open  = 1'b0;
      win_start = '0;
      errors    = 0;
      clear_stats();
    endfunction

    function void clear_stats();
      foreach (count_tab[k]) begin
        count_tab[k] = '0;
        sum_tab[k]   = '0;
        peak_tab[k]  = '0;
        low_tab[k]   = '0;
        high_tab[k]  = '0;
      end
    endfunction

    function void set_reg(reg_idx_e idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_INTERVAL: interval = value[IVL_W-1:0];
        REG_LOW_THR:  low_thr  = value[DUR_W-1:0];
        REG_HIGH_THR: high_thr = value[DUR_W-1:0];
        default: ;
      endcase
    endfunction

    function void add_sample(timing_sample_t s);
      int unsigned   p;
      logic [SUM_W:0] wide_sum;
      longint        elapsed;
      probe_stats_t  row;
      if (!win_open) begin
        win_open  = 1'b1;
        win_start = s.ts;
      end
      p = 32'(s.probe);
      if (p < PROBES) begin
        if (count_tab[p] != '1) count_tab[p] = count_tab[p] + CNT_W'(1);
        wide_sum   = {1'b0, sum_tab[p]} + (SUM_W + 1)'(s.dur);
        sum_tab[p] = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
        if (s.dur > peak_tab[p]) peak_tab[p] = s.dur;
        if (s.dur >= low_thr && low_tab[p] != '1) low_tab[p] = low_tab[p] + CNT_W'(1);
        if (s.dur >= high_thr && high_tab[p] != '1) high_tab[p] = high_tab[p] + CNT_W'(1);
      end
      // signed: a timestamp behind the window start never reports
      elapsed = longint'(s.ts) - longint'(win_start);
      if (elapsed < longint'(interval)) return;
      for (int k = 0; k < PROBES; k++) begin
        row.probe      = PROBE_W'(k);
        row.wlen       = TS_W'(elapsed);
        row.total      = count_tab[k];
        row.sum        = sum_tab[k];
        row.peak       = peak_tab[k];
        row.above_low  = low_tab[k];
        row.above_high = high_tab[k];
        row.last       = (k == PROBES - 1);
        expected_reports.push_back(row);
      end
      clear_stats();
      win_start = s.ts;
    endfunction

    task report_error(string what);
      errors++;
      if (errors <= 100) $display("ERROR @%0t: %s", $time, what);
    endtask

    task compare_field(string name, logic [PROBE_W-1:0] probe, logic [SUM_W-1:0] got,
                       logic [SUM_W-1:0] want);
      if (got !== want)
        report_error($sformatf("probe %0d %s: got 0x%0h, want 0x%0h",
                               probe, name, got, want));
    endtask

    task check_probe_report(probe_stats_t got);
      probe_stats_t want;
      if (expected_reports.size() == 0) begin
        report_error($sformatf("unexpected report item, probe %0d", got.probe));
        return;
      end
      want = expected_reports.pop_front();
      compare_field("report_probe",  want.probe, SUM_W'(got.probe), SUM_W'(want.probe));
      compare_field("window_length", want.probe, SUM_W'(got.wlen),  SUM_W'(want.wlen));
      compare_field("sample_total",  want.probe, SUM_W'(got.total), SUM_W'(want.total));
      compare_field("duration_sum",  want.probe, got.sum,           want.sum);
      compare_field("duration_peak", want.probe, SUM_W'(got.peak),  SUM_W'(want.peak));
      compare_field("above_low",     want.probe, SUM_W'(got.above_low),
                    SUM_W'(want.above_low));
      compare_field("above_high",    want.probe, SUM_W'(got.above_high),
                    SUM_W'(want.above_high));
      compare_field("final_entry",   want.probe, SUM_W'(got.last),  SUM_W'(want.last));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // DUT signals
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // probe_id, duration, timestamp, zero pad
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // report_probe, window_length, sample_total,
                                        // duration_sum, duration_peak, above_low,
                                        // above_high, zero pad
  logic                 m_axis_tlast;   // final_entry
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  probe_stats_tracker   tracker;
  logic [TS_W-1:0]      ts_now;          // latest forward timestamp offered
  int                   tx_run_left;     // remaining no-gap items on the sender side
  int                   rx_run_left;     // same for the receiver
  int                   rx_hold_cycles;  // request for a long receiver hold-off

  always #6 clk_i = ~clk_i;

  windowed_latency_stats_monitor_core #(
    .NUM_PROBES(PROBES)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  // ---------------------------------------------------------------------------
  // Random idle gap before each item, with occasional back-to-back stretches.
  function automatic int draw_gap(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run_left = $urandom_range(16, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       return raw[DUR_W-1:0];
      1:       return DUR_W'($urandom_range(0, 1000));
      2:       return tracker.low_thr + DUR_W'($urandom_range(0, 2)) - DUR_W'(1);
      3:       return tracker.high_thr + DUR_W'($urandom_range(0, 2)) - DUR_W'(1);
      4:       return DUR_MAX;
      5:       return '0;
      default: return DUR_W'($urandom_range(0, 2_000_000));
    endcase
  endfunction

  // Mostly forward steps within the window, with exact and one-short hits on
  // the report boundary and the odd jump back behind the window start.
  function automatic logic [TS_W-1:0] pick_timestamp(input bit force_hit);
    logic [63:0] base;
    logic [63:0] raw;
    base = {{(64 - TS_W){1'b0}}, tracker.win_start};
    raw  = {$urandom, $urandom};
    if (force_hit) return TS_W'(base + 64'(tracker.interval));
    case ($urandom_range(0, 11))
      0, 1:    return TS_W'(base + 64'(tracker.interval));
      2:       return TS_W'(base + 64'(tracker.interval) - 64'd1);
      3:       return tracker.win_start - TS_W'(raw % (base + 64'd1));
      default: return ts_now + TS_W'($urandom_range(0, tracker.interval / 4 + 3));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stream driver: valid stays high across back-to-back items.
  task automatic send_sample(input timing_sample_t s);
    int gap;
    gap = draw_gap(tx_run_left);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({s.ts, s.dur, s.probe});
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.add_sample(s);
    if (s.ts > ts_now) ts_now = s.ts;
  endtask

  task automatic offer(input int probe, input logic [DUR_W-1:0] dur,
                       input logic [TS_W-1:0] ts);
    timing_sample_t s;
    s.probe = PROBE_W'(probe);
    s.dur   = dur;
    s.ts    = ts;
    send_sample(s);
  endtask

  task automatic run_random(input int n, input bit force_hit);
    timing_sample_t s;
    repeat (n) begin
      s.probe = PROBE_W'($urandom_range(0, PROBES - 1));
      s.dur   = pick_duration();
      s.ts    = pick_timestamp(force_hit);
      send_sample(s);
    end
  endtask

  // Sender pause: drop valid and wait until every report item has been seen,
  // then give the block time to finish any sample still in flight.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (tracker.expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // APB write: setup phase, then access until pready, then an idle phase.
  task automatic apb_write(input reg_idx_e idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [IVL_W-1:0] interval,
                           input logic [DUR_W-1:0] low_thr,
                           input logic [DUR_W-1:0] high_thr);
    wait_idle();
    apb_write(REG_INTERVAL, APB_DW'(interval));
    apb_write(REG_LOW_THR,  APB_DW'(low_thr));
    apb_write(REG_HIGH_THR, APB_DW'(high_thr));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a long hold-off on request.
  initial begin : report_sink
    int gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      gap = draw_gap(rx_run_left);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      tracker.check_probe_report('{probe:      m_axis_tdata[5:0],
                                   wlen:       m_axis_tdata[52:6],
                                   total:      m_axis_tdata[84:53],
                                   sum:        m_axis_tdata[148:85],
                                   peak:       m_axis_tdata[188:149],
                                   above_low:  m_axis_tdata[220:189],
                                   above_high: m_axis_tdata[252:221],
                                   last:       m_axis_tlast});
    end
  end

  // Watchdog: a hung handshake or missing report ends the run as a failure.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  initial begin : stimulus
    tracker        = new();
    ts_now         = '0;
    tx_run_left    = 0;
    rx_run_left    = 0;
    rx_hold_cycles = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset thresholds and interval (1000 ms). First sample opens the window.
    offer(0, '0, 100);
    offer(63, DUR_MAX, 150);
    offer(1, 40'd249_999, 200);       // just under low threshold
    offer(1, 40'd250_000, 210);       // at low threshold
    offer(1, 40'd999_999, 220);       // just under high threshold
    offer(1, 40'd1_000_000, 230);     // at high threshold
    offer(2, 5, 50);                  // behind window start: no report
    offer(3, 7, 1099);                // one ms short of the interval
    offer(4, 9, 1100);                // exactly the interval: report
    offer(5, 11, 1100);               // fresh window, zero elapsed
    offer(6, 13, 0);                  // far behind: no report
    offer(7, 1, 2100);                // report again
    offer(8, 2, 47'd2100 + (47'd1 << 40));  // long window

    // Zero interval: anything not behind the window start reports.
    // Low threshold at zero counts every sample, high at max only the max.
    configure('0, '0, DUR_MAX);
    offer(9, '0, ts_now);
    offer(10, DUR_MAX, ts_now + TS_W'(5));
    offer(11, 3, ts_now - TS_W'(1));
    run_random(10, 1'b0);

    // Longest interval; thresholds swapped to the other extremes.
    configure('1, DUR_MAX, '0);
    run_random(40, 1'b0);

    // Moderate settings. The receiver holds off while triggering samples keep
    // coming, so the output backs up and the input stalls during the walk.
    configure(IVL_W'($urandom_range(1, 2000)), DUR_W'($urandom_range(0, 400_000)),
              DUR_W'($urandom_range(200_000, 2_000_000)));
    rx_hold_cycles = HOLD_CYC;
    run_random(6, 1'b1);
    wait_idle();
    run_random(120, 1'b0);

    // Upper half of the timestamp range, random interval and thresholds.
    configure($urandom, DUR_W'({$urandom, $urandom}), DUR_W'({$urandom, $urandom}));
    ts_now = (TS_W'(1) << (TS_W - 1)) + TS_W'($urandom_range(0, 1000));
    run_random(80, 1'b0);

    // Top of the timestamp range with a zero interval.
    configure('0, LOW_THR_RST, HIGH_THR_RST);
    offer(12, 77, TS_MAX);
    offer(63, '0, TS_MAX);
    offer(5, 5, '0);

    wait_idle();
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
